### sv/multi_stream_lcg_range_generator_top_defines.svh
// Assertion macros for the multi-stream LCG range generator.
// Included by the top level, which supplies clock, reset and expressions.
`ifndef MULTI_STREAM_LCG_RANGE_GENERATOR_TOP_DEFINES_SVH
`define MULTI_STREAM_LCG_RANGE_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSLRG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mslrg: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSLRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mslrg: next-cycle check failed");

`endif

### sv/mslrg_pkg.sv
// Shared widths and constants of the multi-stream LCG range generator.
// No dependencies; used by the channel interfaces and the top level.
package mslrg_pkg;

    localparam int THREADS_DEFAULT = 16;

    localparam int SEED_W   = 32;
    localparam int STREAM_W = 5;
    localparam int IMAX_W   = 31;
    localparam int VALUE_W  = 31;

    // Integer scale: imax with ten fractional bits of 0.999 (1023/1024).
    localparam int FRAC_BITS = 10;
    localparam int SCALE_W   = IMAX_W + FRAC_BITS;
    localparam int LO_W      = 20;
    localparam int HI_W      = SCALE_W - LO_W;
    localparam int PROD_W    = VALUE_W + HI_W;

    localparam logic [SEED_W-1:0]    LCG_MUL   = 32'd1103515245;
    localparam logic [SEED_W-1:0]    LCG_ADD   = 32'd12345;
    localparam logic [FRAC_BITS-1:0] FRAC_ONES = 10'h3FF;

    typedef enum logic {
        REQ_INTEGER  = 1'b0,
        REQ_FRACTION = 1'b1
    } t_req_type;

endpackage

### sv/mslrg_req_if.sv
// Request channel of the generator: valid/ready plus mode, stream and bound.
// Depends on mslrg_pkg for the field widths.
interface mslrg_req_if
    import mslrg_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [STREAM_W-1:0] stream;
    logic [IMAX_W-1:0]   imax;

    modport source (output valid, output req_type, output stream, output imax, input ready);
    modport sink   (input valid, input req_type, input stream, input imax, output ready);
endinterface

### sv/mslrg_rsp_if.sv
// Result channel of the generator: valid/ready plus the 31-bit value.
// Depends on mslrg_pkg for the field width.
interface mslrg_rsp_if
    import mslrg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

### sv/multi_stream_lcg_range_generator_top.sv
// Each request passes the slot memory read, the LCG multiply and write-back, and the
// two-step integer scaling; no new request is taken until the last has reached the
// output register, and ST_SUM waits while that register is full and not being read.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active low) clears the seed and the slot valid bits, so every
// slot reads as the seed; no clearing pass runs.
module multi_stream_lcg_range_generator_top
    import mslrg_pkg::*;
#(
    parameter int THREADS = THREADS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SEED_W-1:0] i_cfg_wdata,
    mslrg_req_if.sink         i_req,
    mslrg_rsp_if.source       o_rsp
);

`include "multi_stream_lcg_range_generator_top_defines.svh"

    localparam int SLOTS  = THREADS + 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_SUM
    } t_state;

    t_state r_state;

    logic [SEED_W-1:0]  r_seed;
    logic [SLOTS-1:0]   r_slot_valid;
    logic [SEED_W-1:0]  r_slot_mem [SLOTS];

    logic               r_type;
    logic [SLOT_W-1:0]  r_slot;
    logic [IMAX_W-1:0]  r_imax;
    logic [SEED_W-1:0]  r_rd_data;
    logic               r_rd_valid;
    logic [VALUE_W-1:0] r_ival;
    logic [PROD_W-1:0]  r_prod_hi;
    logic [PROD_W-1:0]  r_prod_lo;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;

    logic               req_fire;
    logic               out_load;
    logic [SLOT_W-1:0]  req_slot;
    logic [SEED_W-1:0]  cur_state;
    logic [SEED_W-1:0]  n_next;
    logic [SCALE_W-1:0] scale;
    logic [HI_W-1:0]    scale_hi;
    logic [LO_W-1:0]    scale_lo;
    logic [PROD_W-1:0]  n_prod_hi;
    logic [PROD_W-1:0]  n_prod_lo;
    logic [PROD_W:0]    prod_sum;
    logic [VALUE_W-1:0] int_value;

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_load    = (r_state == ST_SUM) && (!r_out_valid || o_rsp.ready);

    // Streams above the shared slot fold onto it.
    always_comb begin
        if (32'(i_req.stream) > 32'(THREADS)) begin
            req_slot = SLOT_W'(THREADS);
        end else begin
            req_slot = SLOT_W'(i_req.stream);
        end
    end

    // A slot not written since the last seed load still holds the seed.
    assign cur_state = r_rd_valid ? r_rd_data : r_seed;
    assign n_next    = cur_state * LCG_MUL + LCG_ADD;

    assign scale     = {r_imax, FRAC_ONES};
    assign scale_hi  = scale[SCALE_W-1:LO_W];
    assign scale_lo  = scale[LO_W-1:0];
    assign n_prod_hi = PROD_W'(r_ival) * PROD_W'(scale_hi);
    assign n_prod_lo = PROD_W'(r_ival) * PROD_W'(scale_lo);
    assign prod_sum  = (PROD_W+1)'(r_prod_hi) + (PROD_W+1)'(r_prod_lo >> LO_W);
    assign int_value = prod_sum[HI_W+VALUE_W-1:HI_W];

    // Slot memory: read on the request transaction, written back in the following cycle (ST_READ).
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_rd_data <= r_slot_mem[req_slot];
        end
        if (r_state == ST_READ) begin
            r_slot_mem[r_slot] <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed       <= '0;
            r_slot_valid <= '0;
        end else if (i_cfg_we) begin
            r_seed       <= i_cfg_wdata;
            r_slot_valid <= '0;
        end else if (r_state == ST_READ) begin
            r_slot_valid[r_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_type     <= i_req.req_type;
            r_slot     <= req_slot;
            r_imax     <= i_req.imax;
            r_rd_valid <= r_slot_valid[req_slot];
        end
        if (r_state == ST_READ) begin
            r_ival <= n_next[VALUE_W-1:0];
        end
        if (r_state == ST_MUL) begin
            r_prod_hi <= n_prod_hi;
            r_prod_lo <= n_prod_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_value <= (r_type == REQ_FRACTION) ? r_ival : int_value;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (req_fire) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.value = r_out_value;

    `MSLRG_ASSERT_IMP(a_int_in_range, i_clk, i_rst_n, (r_state == ST_SUM) && (r_type == REQ_INTEGER), int_value <= r_imax)
    `MSLRG_ASSERT_NEXT(a_slot_marked, i_clk, i_rst_n, (r_state == ST_READ) && !i_cfg_we, r_slot_valid[$past(r_slot)])
    `MSLRG_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, out_load, r_out_valid && (r_state == ST_IDLE))

endmodule
